// ----- design/iplpt_pkg.sv -----
// Package for the IPv6 longest prefix table: beat structs, entry layout,
// sequencer states and size constants. No dependencies.
package iplpt_pkg;

    localparam int TableDepthDefault = 64;
    localparam logic [7:0] FullLen = 8'd128;
    localparam int EntryW = 64 + 64 + 8 + 64 + 64 + 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  pfx_len;
        logic [63:0] hop_hi_in;
        logic [63:0] hop_lo_in;
        logic [31:0] port_in;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] hop_hi_out;
        logic [63:0] hop_lo_out;
        logic [31:0] port_out;
        logic        status;
    } t_rsp;

    typedef struct packed {
        logic [63:0] pfx_hi;
        logic [63:0] pfx_lo;
        logic [7:0]  len;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic [31:0] port;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

// ----- design/ipv6_longest_prefix_table.sv -----
// IPv6 longest prefix table: ordered route store, walked entry by entry.
// Each beat reads and then compares the stored entries in turn, as set by the
// single RAM read port; busy throughout, so a new beat waits until it is done.
// Results appear for one cycle on o_valid; the receiver cannot stall.
// Reset clears the entry count and the sequencer; the RAM holds no reset.
// Depends on iplpt_pkg and iplpt_ram.
module ipv6_longest_prefix_table #(
    parameter int TABLE_DEPTH = iplpt_pkg::TableDepthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  iplpt_pkg::t_req   i_req,
    output logic              o_valid,
    output iplpt_pkg::t_rsp   o_rsp
);
    import iplpt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_w, n_w;
    logic          r_found, n_found;
    logic [7:0]    r_best_len, n_best_len;
    logic [AW-1:0] r_best, n_best;
    t_rsp          r_rsp, n_rsp;
    logic          r_valid, n_valid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [7:0]    len_sat;
    logic [127:0]  mask;
    logic          same, match;

    iplpt_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Compare the fetched entry with the request.
    always_comb begin
        mask = (rdata.len == 8'd0) ? 128'd0
             : ~(128'd0) << (8'd128 - rdata.len);
        same = (rdata.pfx_hi == r_req.addr_hi) && (rdata.pfx_lo == r_req.addr_lo)
            && (rdata.len == r_req.pfx_len);
        match = ((({rdata.pfx_hi, rdata.pfx_lo} ^ {r_req.addr_hi, r_req.addr_lo})
            & mask) == 128'd0) && (rdata.len >= r_best_len);
    end

    assign len_sat = (i_req.pfx_len > FullLen) ? FullLen : i_req.pfx_len;

    // Sequencer: next state, RAM control and result.
    always_comb begin
        n_state = r_state; n_req = r_req; n_count = r_count; n_k = r_k; n_w = r_w;
        n_found = r_found; n_best_len = r_best_len; n_best = r_best;
        n_rsp = r_rsp; n_valid = 1'b0;
        we = 1'b0; waddr = r_w[AW-1:0]; wdata = rdata; raddr = r_k[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_req.pfx_len = len_sat;
                    n_k = '0; n_w = '0; n_found = 1'b0;
                    n_best_len = '0; n_best = '0;
                    n_rsp = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_k >= r_count) begin
                    n_state = ST_DONE;
                    case (t_mode'(r_req.mode))
                        MODE_INSERT: begin
                            if (r_count >= DepthC) begin
                                n_rsp.status = 1'b1;
                            end else begin
                                we = 1'b1;
                                waddr = r_count[AW-1:0];
                                wdata = '{r_req.addr_hi, r_req.addr_lo, r_req.pfx_len,
                                          r_req.hop_hi_in, r_req.hop_lo_in, r_req.port_in};
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_DELETE: n_count = r_w;
                        MODE_LOOKUP: begin
                            if (r_found) begin
                                raddr = r_best;
                                n_state = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_k = r_k + 1'b1;
                n_state = ST_READ;
                case (t_mode'(r_req.mode))
                    MODE_INSERT: begin
                        if (same) begin
                            we = 1'b1;
                            waddr = r_k[AW-1:0];
                            wdata.hop_hi = r_req.hop_hi_in;
                            wdata.hop_lo = r_req.hop_lo_in;
                            wdata.port = r_req.port_in;
                            n_state = ST_DONE;
                        end
                    end
                    MODE_DELETE: begin
                        if (!same) begin
                            we = (r_w != r_k);
                            n_w = r_w + 1'b1;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (match) begin
                            n_found = 1'b1;
                            n_best_len = rdata.len;
                            n_best = r_k[AW-1:0];
                        end
                    end
                    default: n_k = r_count;
                endcase
            end
            ST_FETCH: begin
                n_rsp.hit = 1'b1;
                n_rsp.hop_hi_out = rdata.hop_hi;
                n_rsp.hop_lo_out = rdata.hop_lo;
                n_rsp.port_out = rdata.port;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_k <= n_k; r_w <= n_w; r_found <= n_found;
        r_best_len <= n_best_len; r_best <= n_best; r_rsp <= n_rsp;
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp = r_rsp;
endmodule

// ----- design/iplpt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module iplpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
